[sv/rhos_pkg.sv]
// Shared types and constants for the recursive higher-order statistic block.
`timescale 1ns / 1ps

package rhos_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_C_WIN      = 2'd0;
   localparam logic [1:0] CSR_SIGMA_MIN  = 2'd1;
   localparam logic [1:0] CSR_STAT_ORDER = 2'd2;

   // Register reset values
   localparam logic [15:0] C_WIN_RESET      = 16'd655;
   localparam logic [63:0] SIGMA_MIN_RESET  = 64'hffff_ffff_ffff_ffff;
   localparam logic [2:0]  STAT_ORDER_RESET = 3'd4;

   // Output format and weight constants
   localparam int          OUT_FRAC = 16;
   localparam logic [16:0] Q_ONE    = 17'h10000;
   localparam int          Q_BITS   = 32;

   // Main sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAN,
      ST_MAG,
      ST_SQ,
      ST_VAR_NEW,
      ST_VAR_OLD,
      ST_NUM_PREP,
      ST_NUM,
      ST_DEN_PREP,
      ST_DEN,
      ST_DIV_INIT,
      ST_DIV,
      ST_CLAMP,
      ST_STAT,
      ST_DONE
   } rhos_state_type;

   // Multiplier phases
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HI,
      PH_SUM
   } rhos_phase_type;

   // Request to the shared 64 x 32 multiplier
   typedef struct packed {
      logic        start;
      logic [63:0] mult;
      logic [31:0] mcand;
   } rhos_mreq_type;

   // Response from the shared multiplier
   typedef struct packed {
      logic        done;
      logic [95:0] prod;
   } rhos_mrsp_type;

endpackage

[sv/rhos_wmul.sv]
// Shared 64 x 32 unsigned multiplier built from one 32 x 32 multiplier: low product, high product, then sum.
`timescale 1ns / 1ps

module rhos_wmul import rhos_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  rhos_mreq_type mreq,
   output rhos_mrsp_type mrsp
);

   rhos_phase_type ph_ff, ph_in;
   logic [63:0]    p_ff, p_in;
   logic [63:0]    lo_ff, lo_in;
   logic [31:0]    uh_ff, uh_in;
   logic [31:0]    m_ff, m_in;
   logic [31:0]    op_a, op_b;
   logic [63:0]    mul_out;

   // Pick the operand pair for this cycle
   always_comb begin
      if (ph_ff == PH_HI) begin
         op_a = uh_ff;
         op_b = m_ff;
      end else begin
         op_a = mreq.mult[31:0];
         op_b = mreq.mcand;
      end
   end

   assign mul_out = op_a * op_b;

   // Phase sequencing: low product, high product, then sum
   always_comb begin
      ph_in = ph_ff;
      p_in  = p_ff;
      lo_in = lo_ff;
      uh_in = uh_ff;
      m_in  = m_ff;
      case (ph_ff)
         PH_IDLE, PH_SUM: begin
            ph_in = PH_IDLE;
            if (mreq.start) begin
               p_in  = mul_out;
               uh_in = mreq.mult[63:32];
               m_in  = mreq.mcand;
               ph_in = PH_HI;
            end
         end
         PH_HI: begin
            lo_in = p_ff;
            p_in  = mul_out;
            ph_in = PH_SUM;
         end
         default: begin
            ph_in = PH_IDLE;
         end
      endcase
   end

   assign mrsp.done = (ph_ff == PH_SUM);
   assign mrsp.prod = {32'd0, lo_ff} + {p_ff, 32'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE;
      end else begin
         ph_ff <= ph_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff  <= p_in;
      lo_ff <= lo_in;
      uh_ff <= uh_in;
      m_ff  <= m_in;
   end

endmodule

[sv/recursive_higher_order_statistic.sv]
// Top level: recursive mean, variance and higher-order statistic on a sample stream.
// rsp_tvalid rises after the mean, square and variance updates, the power passes that
// stat_order needs, the divide, clamp and statistic update; a zero variance with
// stat_order/2 nonzero skips the divide. A power pass is 9 limbs; the quotient comes from
// a compare-subtract loop. A new sample waits for the last: req_tready is high only while
// idle, and a waiting result holds the sequencer. Synchronous reset clears estimates and loads defaults.
`timescale 1ns / 1ps

module recursive_higher_order_statistic import rhos_pkg::*; #(
   parameter int SAMPLE_BITS = 24,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [8*((SAMPLE_BITS+7)/8)-1:0]     req_tdata,   // sample
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [31:0]                          rsp_tdata,   // hos_value
   output logic                                 rsp_tuser,   // saturated
   input  logic                                 csr_we,
   input  logic [1:0]                           csr_addr,
   input  logic [63:0]                          csr_wdata
);

   localparam int MEAN_W   = SAMPLE_BITS + FRAC_BITS;
   localparam int W        = MEAN_W + 1;
   localparam int POW_BITS = (7 * W > 192) ? 7 * W : 192;
   localparam int LIMBS    = (POW_BITS + 31) / 32;
   localparam int LIMB_W   = LIMBS * 32;
   localparam int LIMB_CW  = $clog2(LIMBS);
   localparam int DIV_W    = LIMB_W + 4 * FRAC_BITS + Q_BITS + 1;

   rhos_state_type     state_ff, state_in;
   logic [15:0]        c_win_ff, c_win_in;
   logic [63:0]        sigma_ff, sigma_in;
   logic [2:0]         order_ff, order_in;
   logic [MEAN_W-1:0]  mean_ff, mean_in;
   logic [63:0]        var_ff, var_in;
   logic [31:0]        stat_ff, stat_in;
   logic               issued_ff, issued_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] x_ff, x_in;
   logic [W-1:0]       mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [LIMB_W-1:0]  work_ff, work_in;
   logic [63:0]        carry_ff, carry_in;
   logic [LIMB_CW-1:0] limb_ff, limb_in;
   logic [2:0]         pass_ff, pass_in;
   logic [63:0]        acc_ff, acc_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   dsh_ff, dsh_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [31:0]        q_ff, q_in;
   logic               ovf_ff, ovf_in;
   logic [31:0]        ratio_ff, ratio_in;
   logic               sat_ff, sat_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_sat_ff, rsp_sat_in;

   rhos_mreq_type      mreq;
   rhos_mrsp_type      mrsp;

   logic [W-1:0]       x_w, mean_w, diff, vflip, mag, mean_delta;
   logic               sq_sat;
   logic [63:0]        sq, vt;
   logic [95:0]        limb_sum;
   logic               last_limb, pass_end;
   logic [2:0]         p_ord, k_ord;
   logic [32:0]        sdiff, sflip;
   logic [31:0]        stat_delta;
   logic               ge;
   logic [DIV_W-1:0]   den_ext, den_shift;
   logic               neg_r, big_pos, big_neg;
   logic               mul_state;

   // Shared multiplier
   rhos_wmul u_wmul (
      .clock (clock),
      .reset (reset),
      .mreq  (mreq),
      .mrsp  (mrsp)
   );

   // Centered sample and its magnitude
   assign x_w    = {x_ff[SAMPLE_BITS-1], x_ff, {FRAC_BITS{1'b0}}};
   assign mean_w = {mean_ff[MEAN_W-1], mean_ff};
   assign diff   = x_w - mean_w;
   assign vflip  = {~diff[W-1], diff[W-2:0]};
   assign mag    = diff[W-1] ? (~diff + W'(1)) : diff;

   // floor(v * c / 2^16) from the offset product
   assign mean_delta = mrsp.prod[16 +: W] - (W'(c_win_ff) << (W - 17));

   // Square shifted down, saturated to 64 bits
   assign sq_sat = |work_ff[LIMB_W-1:64+FRAC_BITS];
   assign sq     = sq_sat ? 64'hffff_ffff_ffff_ffff : work_ff[FRAC_BITS +: 64];

   assign vt = acc_ff + mrsp.prod[16 +: 64];

   // Limb pass accumulation
   assign limb_sum  = mrsp.prod + {32'd0, carry_ff};
   assign last_limb = (limb_ff == LIMB_CW'(LIMBS - 1));
   assign pass_end  = mrsp.done && last_limb;

   assign p_ord = {1'b0, order_ff[2:1]};
   assign k_ord = order_ff - p_ord;

   // Statistic update operands
   assign sdiff      = {ratio_ff[31], ratio_ff} - {stat_ff[31], stat_ff};
   assign sflip      = {~sdiff[32], sdiff[31:0]};
   assign stat_delta = mrsp.prod[47:16] - {c_win_ff, 16'd0};

   // Divider compare and denominator alignment
   assign ge      = (rem_ff >= dsh_ff);
   assign den_ext = DIV_W'({work_ff, 32'd0});

   always_comb begin
      case (k_ord)
         3'd1:    den_shift = den_ext << FRAC_BITS;
         3'd2:    den_shift = den_ext << (2 * FRAC_BITS);
         3'd3:    den_shift = den_ext << (3 * FRAC_BITS);
         3'd4:    den_shift = den_ext << (4 * FRAC_BITS);
         default: den_shift = den_ext;
      endcase
   end

   assign neg_r   = order_ff[0] && neg_ff;
   assign big_pos = ovf_ff || q_ff[31];
   assign big_neg = ovf_ff || (q_ff[31] && (|q_ff[30:0]));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_MEAN;
         end
         ST_MEAN: begin
            if (mrsp.done) state_in = ST_MAG;
         end
         ST_MAG: begin
            state_in = ST_SQ;
         end
         ST_SQ: begin
            if (pass_end) state_in = ST_VAR_NEW;
         end
         ST_VAR_NEW: begin
            if (mrsp.done) state_in = ST_VAR_OLD;
         end
         ST_VAR_OLD: begin
            if (mrsp.done) state_in = ST_NUM_PREP;
         end
         ST_NUM_PREP: begin
            if (p_ord != 3'd0 && var_ff == 64'd0) state_in = ST_STAT;
            else if (order_ff > 3'd2)             state_in = ST_NUM;
            else                                  state_in = ST_DEN_PREP;
         end
         ST_NUM: begin
            if (pass_end && pass_ff == 3'd1) state_in = ST_DEN_PREP;
         end
         ST_DEN_PREP: begin
            if (p_ord > 3'd1) state_in = ST_DEN;
            else              state_in = ST_DIV_INIT;
         end
         ST_DEN: begin
            if (pass_end && pass_ff == 3'd1) state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == 6'd0) state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            state_in = ST_STAT;
         end
         ST_STAT: begin
            if (mrsp.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Multiplier operands per state
   always_comb begin
      mul_state  = 1'b1;
      mreq.mult  = 64'd0;
      mreq.mcand = 32'd0;
      case (state_ff)
         ST_MEAN: begin
            mreq.mult  = 64'(vflip);
            mreq.mcand = 32'(c_win_ff);
         end
         ST_SQ, ST_NUM: begin
            mreq.mult  = 64'(mag_ff);
            mreq.mcand = work_ff[31:0];
         end
         ST_DEN: begin
            mreq.mult  = var_ff;
            mreq.mcand = work_ff[31:0];
         end
         ST_VAR_NEW: begin
            mreq.mult  = sq;
            mreq.mcand = 32'(c_win_ff);
         end
         ST_VAR_OLD: begin
            mreq.mult  = var_ff;
            mreq.mcand = 32'(Q_ONE - {1'b0, c_win_ff});
         end
         ST_STAT: begin
            mreq.mult  = 64'(sflip);
            mreq.mcand = 32'(c_win_ff);
         end
         default: begin
            mul_state = 1'b0;
         end
      endcase
      mreq.start = mul_state && !issued_ff;
   end

   // Datapath and handshake outputs
   always_comb begin
      c_win_in     = c_win_ff;
      sigma_in     = sigma_ff;
      order_in     = order_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      stat_in      = stat_ff;
      issued_in    = issued_ff;
      x_in         = x_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      work_in      = work_ff;
      carry_in     = carry_ff;
      limb_in      = limb_ff;
      pass_in      = pass_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      cnt_in       = cnt_ff;
      q_in         = q_ff;
      ovf_in       = ovf_ff;
      ratio_in     = ratio_ff;
      sat_in       = sat_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = (state_ff == ST_IDLE);

      // Register writes
      if (csr_we) begin
         case (csr_addr)
            CSR_C_WIN:      c_win_in = csr_wdata[15:0];
            CSR_SIGMA_MIN:  sigma_in = csr_wdata;
            CSR_STAT_ORDER: order_in = csr_wdata[2:0];
            default:        c_win_in = c_win_ff;
         endcase
      end

      // Mark a multiply as issued, release it when done
      if (mreq.start) issued_in = 1'b1;
      if (mrsp.done)  issued_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in   = req_tdata[SAMPLE_BITS-1:0];
               sat_in = 1'b0;
            end
         end
         ST_MEAN: begin
            if (mrsp.done) mean_in = mean_ff + mean_delta[MEAN_W-1:0];
         end
         ST_MAG: begin
            mag_in   = mag;
            neg_in   = diff[W-1];
            work_in  = LIMB_W'(mag);
            carry_in = 64'd0;
            limb_in  = '0;
         end
         ST_SQ, ST_NUM, ST_DEN: begin
            // Rotate one product limb in at the top
            if (mrsp.done) begin
               work_in  = {limb_sum[31:0], work_ff[LIMB_W-1:32]};
               carry_in = limb_sum[95:32];
               limb_in  = limb_ff + LIMB_CW'(1);
               if (last_limb) begin
                  carry_in = 64'd0;
                  limb_in  = '0;
                  pass_in  = pass_ff - 3'd1;
               end
            end
         end
         ST_VAR_NEW: begin
            if (mrsp.done) acc_in = mrsp.prod[16 +: 64];
         end
         ST_VAR_OLD: begin
            if (mrsp.done) begin
               if (!sigma_ff[63] && vt <= sigma_ff) var_in = sigma_ff;
               else                                 var_in = vt;
            end
         end
         ST_NUM_PREP: begin
            if (p_ord != 3'd0 && var_ff == 64'd0) begin
               // Zero variance: clamp without dividing
               sat_in   = 1'b1;
               ratio_in = neg_r ? 32'h8000_0000 : 32'h7fff_ffff;
            end
            if (order_ff == 3'd0)      work_in = LIMB_W'(1);
            else if (order_ff == 3'd1) work_in = LIMB_W'(mag_ff);
            pass_in = order_ff - 3'd2;
         end
         ST_DEN_PREP: begin
            rem_in = DIV_W'(work_ff) << OUT_FRAC;
            if (p_ord == 3'd0) work_in = LIMB_W'(1);
            else               work_in = LIMB_W'(var_ff);
            pass_in = p_ord - 3'd1;
         end
         ST_DIV_INIT: begin
            dsh_in = den_shift;
            cnt_in = 6'(Q_BITS);
            q_in   = 32'd0;
            ovf_in = 1'b0;
         end
         ST_DIV: begin
            // One quotient bit per cycle, top step flags overflow
            if (ge) rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[30:0], ge};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'(Q_BITS)) ovf_in = ge;
         end
         ST_CLAMP: begin
            if (!neg_r && big_pos) begin
               sat_in   = 1'b1;
               ratio_in = 32'h7fff_ffff;
            end else if (neg_r && big_neg) begin
               sat_in   = 1'b1;
               ratio_in = 32'h8000_0000;
            end else begin
               ratio_in = neg_r ? (~q_ff + 32'd1) : q_ff;
            end
         end
         ST_STAT: begin
            if (mrsp.done) stat_in = stat_ff + stat_delta;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = stat_ff;
               rsp_sat_in   = sat_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_tready;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // Control state, registers and estimates
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         c_win_ff     <= C_WIN_RESET;
         sigma_ff     <= SIGMA_MIN_RESET;
         order_ff     <= STAT_ORDER_RESET;
         mean_ff      <= '0;
         var_ff       <= 64'd0;
         stat_ff      <= 32'd0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         c_win_ff     <= c_win_in;
         sigma_ff     <= sigma_in;
         order_ff     <= order_in;
         mean_ff      <= mean_in;
         var_ff       <= var_in;
         stat_ff      <= stat_in;
      end
   end

   // Working payload
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      work_ff     <= work_in;
      carry_ff    <= carry_in;
      limb_ff     <= limb_in;
      pass_ff     <= pass_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      cnt_ff      <= cnt_in;
      q_ff        <= q_in;
      ovf_ff      <= ovf_in;
      ratio_ff    <= ratio_in;
      sat_ff      <= sat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

endmodule
